@@ rtl/core/radio_frame_receiver_decoder_macros.svh @@
// assertion macros for the radio frame receiver decoder
`ifndef RADIO_FRAME_RECEIVER_DECODER_MACROS_SVH
`define RADIO_FRAME_RECEIVER_DECODER_MACROS_SVH
`ifndef ASSERT_OFF
// checked on clk, masked while arst_n is low
`define RFRD_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("rfrd assertion failed");
// checked on clk, also while arst_n is low
`define RFRD_ASSERT_RST(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("rfrd reset assertion failed");
`else
`define RFRD_ASSERT(label, prop)
`define RFRD_ASSERT_RST(label, prop)
`endif
`endif

@@ rtl/core/rfrd_pkg.sv @@
// shared constants, types and helpers for the radio frame receiver decoder
package rfrd_pkg;

	// frame store sizing
	localparam int BUFFER_DEPTH = 32;
	localparam int FILL_W       = $clog2(BUFFER_DEPTH + 1);
	// only the leading bytes of a frame are ever decoded
	localparam int DECODE_BYTES = 9;
	localparam int IDX_W        = $clog2(DECODE_BYTES);

	// queue between front and back, power of two deep
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	// byte values
	localparam logic [7:0] TERMINATOR       = 8'h7E;
	localparam logic [7:0] MSG_TEST         = 8'h70;
	localparam logic [7:0] MSG_STATUS       = 8'h71;
	localparam logic [7:0] MSG_EMERGENCY    = 8'h50;
	localparam logic [7:0] MSG_SILENCE      = 8'h61;
	localparam logic [7:0] MSG_MISSING      = 8'hD2;
	localparam logic [7:0] CO_CODE          = 8'h41;
	localparam logic [7:0] FIRE_CODE1       = 8'h81;
	localparam logic [7:0] FIRE_CODE2       = 8'h82;
	localparam logic [7:0] STATUS_BASE_MASK = 8'h04;
	localparam logic [7:0] STATUS_BATT_MASK = 8'h42;
	localparam logic [7:0] TEST_PASS_CODE   = 8'h01;

	// minimum frame lengths, terminator included
	localparam int LEN_TEST      = 9;
	localparam int LEN_STATUS    = 8;
	localparam int LEN_EMERGENCY = 7;
	localparam int LEN_SILENCE   = 7;
	localparam int LEN_MISSING   = 10;
	localparam int LEN_MIN       = 2;

	// reset value of the timeout register
	localparam logic [15:0] TIMEOUT_RESET = 16'd100;

	// reported event kinds
	localparam logic [3:0] EV_TEST      = 4'd0;
	localparam logic [3:0] EV_STATUS    = 4'd1;
	localparam logic [3:0] EV_EMERGENCY = 4'd2;
	localparam logic [3:0] EV_SILENCE   = 4'd3;
	localparam logic [3:0] EV_MISSING   = 4'd4;
	localparam logic [3:0] EV_MALFORMED = 4'd5;
	localparam logic [3:0] EV_UNKNOWN   = 4'd6;
	localparam logic [3:0] EV_OVERFLOW  = 4'd7;
	localparam logic [3:0] EV_TIMEOUT   = 4'd8;

	// alarm classes
	localparam logic [1:0] CLS_NONE = 2'd0;
	localparam logic [1:0] CLS_CO   = 2'd1;
	localparam logic [1:0] CLS_FIRE = 2'd2;

	// job kinds passed from front to back
	localparam logic [1:0] JOB_FRAME    = 2'd0;
	localparam logic [1:0] JOB_OVERFLOW = 2'd1;
	localparam logic [1:0] JOB_TIMEOUT  = 2'd2;

	typedef struct packed {
		logic [1:0]                   kind;
		logic [FILL_W-1:0]            len;
		logic [DECODE_BYTES-1:0][7:0] bytes;
	} job_t;

	typedef struct packed {
		logic [3:0]  event_kind;
		logic [7:0]  message_type;
		logic [23:0] device_id;
		logic [15:0] model_code;
		logic [7:0]  event_code;
		logic [7:0]  status_byte;
		logic [1:0]  alarm_class;
		logic        test_passed;
		logic        base_on;
		logic        battery_low;
		logic [5:0]  frame_length;
	} result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// alarm class of an event code byte
	function automatic logic [1:0] alarm_of(input logic [7:0] code);
		logic [1:0] cls;
		cls = CLS_NONE;
		if (code == CO_CODE) begin
			cls = CLS_CO;
		end else if (code == FIRE_CODE1 || code == FIRE_CODE2) begin
			cls = CLS_FIRE;
		end
		return cls;
	endfunction

endpackage

@@ rtl/core/rfrd_channels.sv @@
// valid/ready channel interfaces for input items and decoded results
interface rfrd_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] rx_byte;

	modport source (output valid, output action, output rx_byte, input ready);
	modport sink (input valid, input action, input rx_byte, output ready);
endinterface

interface rfrd_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  event_kind;
	logic [7:0]  message_type;
	logic [23:0] device_id;
	logic [15:0] model_code;
	logic [7:0]  event_code;
	logic [7:0]  status_byte;
	logic [1:0]  alarm_class;
	logic        test_passed;
	logic        base_on;
	logic        battery_low;
	logic [5:0]  frame_length;

	modport source (output valid, output event_kind, output message_type, output device_id,
		output model_code, output event_code, output status_byte, output alarm_class,
		output test_passed, output base_on, output battery_low, output frame_length,
		input ready);
	modport sink (input valid, input event_kind, input message_type, input device_id,
		input model_code, input event_code, input status_byte, input alarm_class,
		input test_passed, input base_on, input battery_low, input frame_length,
		output ready);
endinterface

@@ rtl/core/rfrd_front.sv @@
// front end: frame assembly, overflow and timeout tracking, job issue
module rfrd_front import rfrd_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	rfrd_in_if.sink         in_ch,
	input  logic            cfg_we,
	input  logic [15:0]     cfg_wdata,
	input  q_status_t       q_stat,
	output logic            job_valid,
	output job_t            job
);

	logic [FILL_W-1:0] fill_q, fill_d;
	logic              disc_q, disc_d;
	logic [15:0]       age_q, age_d;
	logic [15:0]       timeout_q;
	logic [7:0]        frame_q [DECODE_BYTES];
	logic              store_we;
	logic [IDX_W-1:0]  store_idx;
	logic [15:0]       age_inc;
	logic              accept;

	// a transfer needs room in the queue for its possible job
	assign in_ch.ready = !q_stat.full;
	assign accept      = in_ch.valid && in_ch.ready;

	assign age_inc   = (age_q == 16'hFFFF) ? age_q : age_q + 16'd1;
	assign store_idx = fill_q[IDX_W-1:0];

	// next state and job
	always_comb begin
		fill_d    = fill_q;
		disc_d    = disc_q;
		age_d     = age_q;
		store_we  = 1'b0;
		job_valid = 1'b0;
		job.kind  = JOB_FRAME;
		job.len   = fill_q + 1'b1;
		for (int i = 0; i < DECODE_BYTES; i++) begin
			job.bytes[i] = (fill_q == FILL_W'(i)) ? in_ch.rx_byte : frame_q[i];
		end
		if (accept) begin
			if (in_ch.action) begin
				age_d = age_inc;
				if ((fill_q != '0 || disc_q) && age_inc >= timeout_q) begin
					fill_d    = '0;
					disc_d    = 1'b0;
					job_valid = 1'b1;
					job.kind  = JOB_TIMEOUT;
				end
			end else if (disc_q) begin
				if (in_ch.rx_byte == TERMINATOR) begin
					fill_d = '0;
					disc_d = 1'b0;
				end
			end else if (fill_q < FILL_W'(BUFFER_DEPTH)) begin
				if (fill_q == '0) begin
					age_d = '0;
				end
				store_we = (fill_q < FILL_W'(DECODE_BYTES));
				fill_d   = fill_q + 1'b1;
				if (in_ch.rx_byte == TERMINATOR) begin
					fill_d    = '0;
					job_valid = 1'b1;
					job.kind  = JOB_FRAME;
				end
			end else begin
				fill_d    = '0;
				disc_d    = 1'b1;
				age_d     = '0;
				job_valid = 1'b1;
				job.kind  = JOB_OVERFLOW;
			end
		end
	end

	// control state and timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			disc_q    <= 1'b0;
			age_q     <= '0;
			timeout_q <= TIMEOUT_RESET;
		end else begin
			fill_q <= fill_d;
			disc_q <= disc_d;
			age_q  <= age_d;
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
		end
	end

	// leading bytes of the frame store
	always_ff @(posedge clk) begin
		for (int i = 0; i < DECODE_BYTES; i++) begin
			if (store_we && store_idx == IDX_W'(i)) begin
				frame_q[i] <= in_ch.rx_byte;
			end
		end
	end

endmodule

@@ rtl/core/rfrd_queue.sv @@
// job queue between front and back
module rfrd_queue import rfrd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  job_t      push_job,
	input  logic      pop,
	output job_t      head_job,
	output q_status_t q_stat
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head_job     = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

@@ rtl/core/rfrd_back.sv @@
// back end: frame decode and result output register
module rfrd_back import rfrd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  job_t      head_job,
	input  q_status_t q_stat,
	output logic      pop,
	rfrd_out_if.source out_ch
);

	result_t           res;
	result_t           res_q;
	logic              valid_q;
	logic              known;
	logic [3:0]        kind_ev;
	logic [FILL_W-1:0] need;

	// take the next job when the output register is free or being emptied
	assign pop = !q_stat.empty && (!valid_q || out_ch.ready);

	// decode of the queue head
	always_comb begin
		res     = '0;
		known   = 1'b1;
		kind_ev = EV_TEST;
		need    = FILL_W'(LEN_TEST);
		case (head_job.kind)
			JOB_OVERFLOW: res.event_kind = EV_OVERFLOW;
			JOB_TIMEOUT:  res.event_kind = EV_TIMEOUT;
			JOB_FRAME: begin
				res.message_type = head_job.bytes[0];
				res.frame_length = 6'(head_job.len);
				case (head_job.bytes[0])
					MSG_TEST: begin
						kind_ev = EV_TEST;
						need    = FILL_W'(LEN_TEST);
					end
					MSG_STATUS: begin
						kind_ev = EV_STATUS;
						need    = FILL_W'(LEN_STATUS);
					end
					MSG_EMERGENCY: begin
						kind_ev = EV_EMERGENCY;
						need    = FILL_W'(LEN_EMERGENCY);
					end
					MSG_SILENCE: begin
						kind_ev = EV_SILENCE;
						need    = FILL_W'(LEN_SILENCE);
					end
					MSG_MISSING: begin
						kind_ev = EV_MISSING;
						need    = FILL_W'(LEN_MISSING);
					end
					default: known = 1'b0;
				endcase
				if (head_job.len < FILL_W'(LEN_MIN)) begin
					res.event_kind = EV_MALFORMED;
				end else if (!known) begin
					res.event_kind = EV_UNKNOWN;
				end else if (head_job.len < need) begin
					res.event_kind = EV_MALFORMED;
				end else begin
					res.event_kind = kind_ev;
					if (kind_ev == EV_MISSING) begin
						res.device_id = {head_job.bytes[6], head_job.bytes[7],
							head_job.bytes[8]};
					end else if (kind_ev == EV_STATUS) begin
						res.device_id   = {head_job.bytes[1], head_job.bytes[2],
							head_job.bytes[3]};
						res.model_code  = {head_job.bytes[4], head_job.bytes[5]};
						res.status_byte = head_job.bytes[6];
						res.base_on     = |(head_job.bytes[6] & STATUS_BASE_MASK);
						res.battery_low = |(head_job.bytes[6] & STATUS_BATT_MASK);
					end else begin
						res.device_id   = {head_job.bytes[1], head_job.bytes[2],
							head_job.bytes[3]};
						res.event_code  = head_job.bytes[4];
						res.status_byte = head_job.bytes[5];
						res.base_on     = 1'b1;
						if (kind_ev == EV_TEST) begin
							res.model_code  = {head_job.bytes[6], head_job.bytes[7]};
							res.test_passed = (head_job.bytes[5] == TEST_PASS_CODE);
						end
						if (kind_ev != EV_SILENCE) begin
							res.alarm_class = alarm_of(head_job.bytes[4]);
						end
					end
				end
			end
			default: res = '0;
		endcase
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res;
		end
	end

	assign out_ch.valid        = valid_q;
	assign out_ch.event_kind   = res_q.event_kind;
	assign out_ch.message_type = res_q.message_type;
	assign out_ch.device_id    = res_q.device_id;
	assign out_ch.model_code   = res_q.model_code;
	assign out_ch.event_code   = res_q.event_code;
	assign out_ch.status_byte  = res_q.status_byte;
	assign out_ch.alarm_class  = res_q.alarm_class;
	assign out_ch.test_passed  = res_q.test_passed;
	assign out_ch.base_on      = res_q.base_on;
	assign out_ch.battery_low  = res_q.battery_low;
	assign out_ch.frame_length = res_q.frame_length;

endmodule

@@ rtl/core/radio_frame_receiver_decoder.sv @@
// top level of the radio frame receiver decoder
//
//  channel   | direction | payload
//  ----------+-----------+---------------------------------------------------
//  in_ch     | sink      | action, rx_byte
//  out_ch    | source    | event_kind .. frame_length, one decoded event
//  cfg_*     | write     | frame_timeout_ticks, 16 bits
//
// One byte or tick is taken every cycle while in_ch.ready is high; the job enters the
// queue at the accepting edge, and its result is valid from the output register once popped.
// in_ch.ready falls only when the four-entry job queue is full, which happens
// when out_ch stalls. Reset clears the fill count, discard flag, frame age,
// queue and output valid at once; no clearing pass is needed.
`include "radio_frame_receiver_decoder_macros.svh"
module radio_frame_receiver_decoder import rfrd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	rfrd_in_if.sink     in_ch,
	rfrd_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic      push;
	logic      pop;
	job_t      new_job;
	job_t      head_job;
	q_status_t q_stat;

	// frame assembly
	rfrd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_stat    (q_stat),
		.job_valid (push),
		.job       (new_job)
	);

	// job queue
	rfrd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (new_job),
		.pop      (pop),
		.head_job (head_job),
		.q_stat   (q_stat)
	);

	// decode and output
	rfrd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_job (head_job),
		.q_stat   (q_stat),
		.pop      (pop),
		.out_ch   (out_ch)
	);

	// no job written into a full queue
	`RFRD_ASSERT(a_no_push_full, push |-> !q_stat.full)
	// no job taken from an empty queue
	`RFRD_ASSERT(a_no_pop_empty, pop |-> !q_stat.empty)
	// a result register that is emptied with nothing queued goes idle
	`RFRD_ASSERT(a_drain_idle, (out_ch.valid && out_ch.ready && q_stat.empty) |=> !out_ch.valid)
	// nothing pending while reset is held
	`RFRD_ASSERT_RST(a_reset_idle, !arst_n |-> (!out_ch.valid && q_stat.empty))

endmodule
